FILE: rtl/blmd_pkg.sv
// ----------------------------------------------------------------------------
// blmd_pkg
// Shared types, constants and decode helpers for the boot-latched memory
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package blmd_pkg;

    localparam int ADDR_BITS       = 16;
    localparam int REG_STORE_WORDS = 32;
    localparam int DATA_BITS       = 8;
    localparam int CFG_BITS        = 16;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic [ADDR_BITS-1:0] HIGH_BIT_MASK  = 16'h8000;
    localparam logic [7:0]           REG_PAGE       = 8'h8c;
    localparam logic [7:0]           ROM_FIRST_PAGE = 8'h80;
    localparam logic [DATA_BITS-1:0] UNDEF_BYTE     = 8'hff;

    // Reset values of the configuration registers
    localparam logic [2:0]           RST_RAM_CODE   = 3'd4;
    localparam logic [7:0]           RST_ROM_LAST   = 8'd135;
    localparam logic [3:0]           RST_PROTECT    = 4'd0;
    localparam logic [ADDR_BITS-1:0] RST_BOOT_LATCH = 16'h8000;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RAM_SIZE_CODE = 2'd0,
        CFG_ROM_LAST_PAGE = 2'd1,
        CFG_PROTECT       = 2'd2,
        CFG_BOOT_LATCH    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_RAM,
        KIND_ROM,
        KIND_REG,
        KIND_UNDEF
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // transaction taken on the input side this cycle
        logic load_out;  // move the finished result into the output register
    } t_cmd;

    function automatic t_kind page_kind(input logic [ADDR_BITS-1:0] addr,
                                        input logic [2:0]           ram_code,
                                        input logic [7:0]           rom_last);
        logic [7:0] page;
        page = addr[15:8];
        if (page == REG_PAGE)
            return KIND_REG;
        if ({1'b0, page} < (9'd1 << ram_code))
            return KIND_RAM;
        if (page >= ROM_FIRST_PAGE && page <= rom_last)
            return KIND_ROM;
        return KIND_UNDEF;
    endfunction

    function automatic logic in_reg_store(input logic [ADDR_BITS-1:0] addr);
        return (addr[15:8] == REG_PAGE) && ({1'b0, addr[7:0]} < 9'(REG_STORE_WORDS));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/blmd_ctrl.sv
// ----------------------------------------------------------------------------
// blmd_ctrl
// Sequencer for the decoder: takes one transaction, waits for the memory
// read, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blmd_ctrl
    import blmd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    output logic o_valid,
    input  wire  i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free       = !r_out_valid || !i_stall;
    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_cmd.accept   = (r_state == S_IDLE) && i_valid;
    assign o_cmd.load_out = (r_state == S_BUSY) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall)
            n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid)
                    n_state = S_BUSY;
            end
            S_BUSY: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/blmd_datapath.sv
// ----------------------------------------------------------------------------
// blmd_datapath
// Configuration registers, address latch, page decode, the 64K byte store
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blmd_datapath
    import blmd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  t_cmd             i_cmd,
    input  wire  [1:0]             i_action,
    input  wire  [ADDR_BITS-1:0]   i_address,
    input  wire  [DATA_BITS-1:0]   i_write_data,
    input  wire                    i_rom_write_enable,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire  [CFG_BITS-1:0]    i_cfg_data,
    output logic [DATA_BITS-1:0]   o_read_data,
    output logic                   o_write_taken
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    logic [2:0]           r_ram_code;
    logic [7:0]           r_rom_last;
    logic [3:0]           r_protect;
    logic [ADDR_BITS-1:0] r_latch;

    logic                 r_is_read;
    logic                 r_undef;
    logic                 r_taken;
    logic [DATA_BITS-1:0] r_mem_q;
    logic [DATA_BITS-1:0] r_read_data;
    logic                 r_write_taken;

    t_action              act;
    logic [ADDR_BITS-1:0] rd_addr;
    t_kind                rd_kind;
    t_kind                wr_kind;
    logic                 wr_land;
    logic                 mem_we;

    assign act = t_action'(i_action);

    // A high read address clears the latch and is never ORed, so the cleared
    // latch value is never needed here.
    assign rd_addr = i_address[15] ? i_address : (i_address | r_latch);
    assign rd_kind = page_kind(rd_addr, r_ram_code, r_rom_last);
    assign wr_kind = page_kind(i_address, r_ram_code, r_rom_last);

    always_comb begin
        unique case (wr_kind)
            KIND_RAM: wr_land = !r_protect[i_address[11:10]];
            KIND_REG: wr_land = in_reg_store(i_address);
            default:  wr_land = i_rom_write_enable;
        endcase
    end

    assign mem_we = i_cmd.accept && (act == ACT_WRITE) && wr_land;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[i_address] <= i_write_data;
        if (i_cmd.accept)
            r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_code <= RST_RAM_CODE;
            r_rom_last <= RST_ROM_LAST;
            r_protect  <= RST_PROTECT;
            r_latch    <= RST_BOOT_LATCH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RAM_SIZE_CODE: r_ram_code <= i_cfg_data[2:0];
                CFG_ROM_LAST_PAGE: r_rom_last <= i_cfg_data[7:0];
                CFG_PROTECT:       r_protect  <= i_cfg_data[3:0];
                CFG_BOOT_LATCH:    r_latch    <= i_cfg_data;
                default:           r_latch    <= r_latch;
            endcase
        end else if (i_cmd.accept) begin
            if (act == ACT_LOAD)
                r_latch <= i_address;
            else if (act == ACT_READ && i_address[15])
                r_latch <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_read <= (act == ACT_READ);
            r_undef   <= (rd_kind == KIND_UNDEF) ||
                         (rd_kind == KIND_REG && !in_reg_store(rd_addr));
            r_taken   <= mem_we;
        end
        if (i_cmd.load_out) begin
            r_read_data   <= !r_is_read ? '0 : (r_undef ? UNDEF_BYTE : r_mem_q);
            r_write_taken <= r_taken;
        end
    end

    assign o_read_data   = r_read_data;
    assign o_write_taken = r_write_taken;

endmodule

`default_nettype wire

FILE: rtl/boot_latched_memory_decoder.sv
// ----------------------------------------------------------------------------
// boot_latched_memory_decoder
// Memory decoder with boot address latch: RAM, ROM, register store and
// undefined pages over a 64K byte store.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  input    | i_valid / o_stall  | i_action, i_address, i_write_data,
//           |                    | i_rom_write_enable
//  output   | o_valid / i_stall  | o_read_data, o_write_taken
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  Each transaction is taken in the idle state, which issues the store
//  access; the busy state then moves the registered read byte into the
//  output register once it is free. No new transaction is taken while busy.
//  A finished result waits in the output register while the next
//  transaction is taken; a stalled result holds the block in its busy cycle.
//  Reset restores configuration defaults and loads the latch with 0x8000;
//  the byte store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_latched_memory_decoder
    import blmd_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire  [1:0]              i_action,
    input  wire  [ADDR_BITS-1:0]    i_address,
    input  wire  [DATA_BITS-1:0]    i_write_data,
    input  wire                     i_rom_write_enable,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic [DATA_BITS-1:0]    o_read_data,
    output logic                    o_write_taken,
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire  [CFG_BITS-1:0]     i_cfg_data
);

    t_cmd cmd;

    blmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    blmd_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_action           (i_action),
        .i_address          (i_address),
        .i_write_data       (i_write_data),
        .i_rom_write_enable (i_rom_write_enable),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_read_data        (o_read_data),
        .o_write_taken      (o_write_taken)
    );

endmodule

`default_nettype wire

FILE: rtl/blmd_checker.sv
// ----------------------------------------------------------------------------
// blmd_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blmd_checker
    import blmd_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_stall,
    input wire                 o_valid,
    input wire                 i_stall,
    input wire [DATA_BITS-1:0] o_read_data,
    input wire                 o_write_taken
);

    // an accepted transaction makes the input side busy in the following cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("input side not busy after an accepted transaction");

    a_stalled_result_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data) && $stable(o_write_taken))
    ) else $error("stalled result changed or dropped");

    // a write that lands never reports read data
    a_taken_no_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_taken) |-> (o_read_data == '0)
    ) else $error("write result carries read data");

    // a new result only follows a busy cycle
    a_result_after_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)
    ) else $error("result appeared without a busy cycle");

endmodule

bind boot_latched_memory_decoder blmd_checker u_blmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_read_data   (o_read_data),
    .o_write_taken (o_write_taken)
);

`default_nettype wire

FILE: verif/tb_boot_latched_memory_decoder.sv
// ----------------------------------------------------------------------------
// tb_boot_latched_memory_decoder
// Self-checking bench for the boot-latched memory decoder. A behavioral
// model of the memory map, the address latch and the byte store predicts
// every result. Stimulus runs directed decode and write-protect cases, then
// random traffic over a sweep of configurations under random sender gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_boot_latched_memory_decoder;
    import blmd_pkg::*;

    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 write_taken;
    } t_bus_result;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [1:0]              i_action;
    logic [ADDR_BITS-1:0]    i_address;
    logic [DATA_BITS-1:0]    i_write_data;
    logic                    i_rom_write_enable;
    logic                    o_valid;
    logic                    i_stall;
    logic [DATA_BITS-1:0]    o_read_data;
    logic                    o_write_taken;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;

    // Memory map model
    logic [2:0]           ram_code_q;
    logic [7:0]           rom_last_q;
    logic [3:0]           protect_q;
    logic [ADDR_BITS-1:0] latch_q;
    logic [7:0]           mem_image [0:65535];
    bit                   mem_valid [0:65535];
    logic [ADDR_BITS-1:0] written_addrs [$];

    t_bus_result pending_results [$];
    int          error_count;
    int          accesses_sent;
    int          burst_left;
    bit          hold_request;

    boot_latched_memory_decoder i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_address          (i_address),
        .i_write_data       (i_write_data),
        .i_rom_write_enable (i_rom_write_enable),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_read_data        (o_read_data),
        .o_write_taken      (o_write_taken),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_kind classify_page(input logic [ADDR_BITS-1:0] a);
        logic [7:0] pg;
        pg = a[15:8];
        if (pg == REG_PAGE)
            return KIND_REG;
        if (int'(pg) < (1 << int'(ram_code_q)))
            return KIND_RAM;
        if (pg >= ROM_FIRST_PAGE && pg <= rom_last_q)
            return KIND_ROM;
        return KIND_UNDEF;
    endfunction

    function automatic bit reg_store_hit(input logic [ADDR_BITS-1:0] a);
        return a[15:8] == REG_PAGE && int'(a[7:0]) < REG_STORE_WORDS;
    endfunction

    function automatic logic [ADDR_BITS-1:0] remap_read(input logic [ADDR_BITS-1:0] a);
        return a[15] ? a : (a | latch_q);
    endfunction

    // True when a read at this bus address never touches an unwritten byte
    function automatic bit read_is_defined(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS-1:0] ea;
        t_kind                k;
        ea = a[15] ? a : (a | latch_q);
        k  = classify_page(ea);
        if (k == KIND_UNDEF || (k == KIND_REG && !reg_store_hit(ea)))
            return 1'b1;
        return mem_valid[ea];
    endfunction

    task automatic decode_access(input t_action act, input logic [ADDR_BITS-1:0] addr,
                                 input logic [7:0] wdata, input logic rwe,
                                 output t_bus_result res);
        logic [ADDR_BITS-1:0] ea;
        t_kind                k;
        logic                 lands;
        res   = '0;
        lands = 1'b0;
        case (act)
            ACT_READ: begin
                ea = remap_read(addr);
                if (addr[15])
                    latch_q = '0;
                k = classify_page(ea);
                if (k == KIND_UNDEF || (k == KIND_REG && !reg_store_hit(ea)))
                    res.read_data = UNDEF_BYTE;
                else
                    res.read_data = mem_image[ea];
            end
            ACT_WRITE: begin
                k = classify_page(addr);
                if (k == KIND_RAM)
                    lands = !protect_q[addr[11:10]];
                else if (k == KIND_REG)
                    lands = reg_store_hit(addr);
                else
                    lands = rwe;
                if (lands) begin
                    mem_image[addr] = wdata;
                    if (!mem_valid[addr]) begin
                        mem_valid[addr] = 1'b1;
                        written_addrs.push_back(addr);
                    end
                end
                res.write_taken = lands;
            end
            ACT_LOAD: begin
                latch_q = addr;
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_access(input t_action act, input logic [ADDR_BITS-1:0] addr,
                               input logic [7:0] wdata, input logic rwe);
        t_bus_result res;
        i_valid            <= 1'b1;
        i_action           <= act;
        i_address          <= addr;
        i_write_data       <= wdata;
        i_rom_write_enable <= rwe;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        decode_access(act, addr, wdata, rwe, res);
        pending_results.push_back(res);
        if (act != ACT_NONE)
            accesses_sent++;
        @(negedge i_clk);
    endtask

    task automatic pace_sender(input int max_gap);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain_block();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_RAM_SIZE_CODE: ram_code_q = value[2:0];
            CFG_ROM_LAST_PAGE: rom_last_q = value[7:0];
            CFG_PROTECT:       protect_q  = value[3:0];
            CFG_BOOT_LATCH:    latch_q    = value;
            default: ;
        endcase
    endtask

    task automatic set_memory_map(input logic [2:0] code, input logic [7:0] last,
                                  input logic [3:0] prot, input logic [15:0] boot);
        drain_block();
        write_reg(CFG_RAM_SIZE_CODE, CFG_BITS'(code));
        write_reg(CFG_ROM_LAST_PAGE, CFG_BITS'(last));
        write_reg(CFG_PROTECT, CFG_BITS'(prot));
        write_reg(CFG_BOOT_LATCH, boot);
    endtask

    function automatic logic [ADDR_BITS-1:0] pick_read_addr();
        logic [ADDR_BITS-1:0] cand;
        logic [ADDR_BITS-1:0] tgt;
        for (int tries = 0; tries < 16; tries++) begin
            if (written_addrs.size() != 0 && $urandom_range(0, 99) < 70) begin
                tgt  = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                cand = tgt[15] ? tgt : (tgt & ~(latch_q & 16'($urandom)));
            end else begin
                cand = 16'($urandom);
            end
            if (read_is_defined(cand))
                return cand;
        end
        // register page beyond the store always answers the undefined byte
        return {REG_PAGE, 8'($urandom_range(REG_STORE_WORDS, 255))};
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_write_addr();
        int sel;
        int ram_top;
        sel     = $urandom_range(0, 99);
        ram_top = (256 << int'(ram_code_q)) - 1;
        if (sel < 40)
            return 16'($urandom_range(0, ram_top));
        if (sel < 60)
            return {REG_PAGE, 8'($urandom_range(0, REG_STORE_WORDS - 1))};
        if (sel < 65)
            return {REG_PAGE, 8'($urandom_range(REG_STORE_WORDS, 255))};
        if (sel < 85 && rom_last_q >= ROM_FIRST_PAGE)
            return {8'($urandom_range(ROM_FIRST_PAGE, rom_last_q)), 8'($urandom)};
        return 16'($urandom);
    endfunction

    // Read a target back, sometimes through a freshly loaded latch
    task automatic read_back(input logic [ADDR_BITS-1:0] tgt, input int max_gap);
        logic [ADDR_BITS-1:0] lat;
        logic [ADDR_BITS-1:0] bus_addr;
        if (!tgt[15] && $urandom_range(0, 1) == 1) begin
            lat = tgt & 16'($urandom);
            pace_sender(max_gap);
            send_access(ACT_LOAD, lat, 8'($urandom), 1'($urandom));
        end
        bus_addr = tgt[15] ? tgt : (tgt & ~(latch_q & 16'($urandom)));
        if (!read_is_defined(bus_addr))
            bus_addr = pick_read_addr();
        pace_sender(max_gap);
        send_access(ACT_READ, bus_addr, 8'($urandom), 1'($urandom));
    endtask

    task automatic run_traffic(input int n_items, input int max_gap);
        int                   stop_at;
        int                   sel;
        logic [ADDR_BITS-1:0] tgt;
        stop_at = accesses_sent + n_items;
        while (accesses_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                pace_sender(max_gap);
                send_access(ACT_READ, pick_read_addr(), 8'($urandom), 1'($urandom));
            end else if (sel < 62) begin
                pace_sender(max_gap);
                send_access(ACT_WRITE, pick_write_addr(), 8'($urandom), 1'($urandom));
            end else if (sel < 82) begin
                tgt = pick_write_addr();
                pace_sender(max_gap);
                send_access(ACT_WRITE, tgt, 8'($urandom), 1'($urandom_range(0, 3) != 0));
                read_back(tgt, max_gap);
            end else if (sel < 94) begin
                pace_sender(max_gap);
                tgt = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom);
                send_access(ACT_LOAD, tgt, 8'($urandom), 1'($urandom));
            end else begin
                pace_sender(max_gap);
                send_access(ACT_NONE, 16'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_decode_basics();
        // latch holds 0x8000 from reset: low reads land in ROM
        send_access(ACT_WRITE, 16'h8010, 8'h3c, 1'b1);
        send_access(ACT_READ,  16'h0010, 8'h00, 1'b0);
        send_access(ACT_WRITE, 16'h8020, 8'h11, 1'b0);
        send_access(ACT_WRITE, 16'h0000, 8'h00, 1'b0);
        send_access(ACT_WRITE, 16'h0fff, 8'hff, 1'b0);
        send_access(ACT_WRITE, 16'h8c00, 8'ha5, 1'b0);
        send_access(ACT_WRITE, 16'h8c1f, 8'h5a, 1'b0);
        send_access(ACT_WRITE, 16'h8c20, 8'h77, 1'b1);
        // high read clears the latch
        send_access(ACT_READ,  16'h8c00, 8'hff, 1'b1);
        send_access(ACT_READ,  16'h8c1f, 8'h00, 1'b0);
        send_access(ACT_READ,  16'h8cff, 8'h00, 1'b0);
        send_access(ACT_READ,  16'h0000, 8'h00, 1'b0);
        send_access(ACT_READ,  16'h0fff, 8'h00, 1'b0);
        send_access(ACT_READ,  16'h7fff, 8'h00, 1'b0);
        send_access(ACT_WRITE, 16'hffff, 8'h81, 1'b1);
        send_access(ACT_WRITE, 16'hfffe, 8'h42, 1'b0);
        send_access(ACT_READ,  16'hffff, 8'h00, 1'b0);
        send_access(ACT_LOAD,  16'h0f00, 8'hff, 1'b1);
        send_access(ACT_READ,  16'h00ff, 8'h00, 1'b0);
        send_access(ACT_NONE,  16'h8000, 8'hff, 1'b1);
        send_access(ACT_READ,  16'h00ff, 8'h00, 1'b0);
    endtask

    task automatic test_write_protect();
        set_memory_map(3'd4, 8'd135, 4'b0101, 16'h0000);
        send_access(ACT_WRITE, 16'h0000, 8'h99, 1'b1);
        send_access(ACT_WRITE, 16'h0400, 8'h66, 1'b0);
        send_access(ACT_WRITE, 16'h0800, 8'h55, 1'b1);
        send_access(ACT_WRITE, 16'h0c00, 8'h44, 1'b0);
        send_access(ACT_WRITE, 16'h1000, 8'h33, 1'b0);
        send_access(ACT_READ,  16'h0400, 8'h00, 1'b0);
        send_access(ACT_READ,  16'h0000, 8'h00, 1'b0);
    endtask

    task automatic test_config_sweep();
        int gaps [3];
        gaps = '{0, 3, 6};
        set_memory_map(3'd4, 8'd135, 4'h0, 16'h8000);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        set_memory_map(3'd0, 8'd128, 4'h0, 16'h0000);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        set_memory_map(3'd7, 8'd255, 4'hf, 16'hffff);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        set_memory_map(3'd7, 8'd200, 4'h0, 16'h0000);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        // last ROM page below the ROM base: no ROM pages at all
        set_memory_map(3'd2, 8'h10, 4'ha, 16'h1234);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        set_memory_map(3'd5, 8'd160, 4'h5, 16'h8000);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        set_memory_map(3'd1, 8'd255, 4'h0, 16'h7f00);
        run_traffic(200, gaps[$urandom_range(0, 2)]);
        set_memory_map(3'($urandom_range(0, 7)), 8'($urandom_range(128, 255)),
                       4'($urandom), 16'($urandom));
        run_traffic(200, gaps[$urandom_range(0, 2)]);
    endtask

    task automatic test_receiver_holdoff();
        drain_block();
        hold_request = 1'b1;
        // keep offering back to back so the block fills and stalls its input
        run_traffic(30, 0);
    endtask

    initial begin : receiver_stall
        int          hold_left;
        int          window;
        int          step_cnt;
        t_stall_mode mode;
        i_stall   = 1'b0;
        hold_left = 0;
        window    = 0;
        step_cnt  = 0;
        mode      = STALL_NONE;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (window == 0) begin
                mode   = t_stall_mode'($urandom_range(0, 3));
                window = $urandom_range(20, 80);
            end
            window--;
            step_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                    default:     i_stall <= ((step_cnt % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_bus_result exp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %0h write_taken %0b",
                       o_read_data, o_write_taken);
                error_count++;
            end else begin
                exp = pending_results.pop_front();
                if (o_read_data !== exp.read_data) begin
                    $error("read_data: expected %0h, actual %0h", exp.read_data, o_read_data);
                    error_count++;
                end
                if (o_write_taken !== exp.write_taken) begin
                    $error("write_taken: expected %0b, actual %0b",
                           exp.write_taken, o_write_taken);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_action           = ACT_READ;
        i_address          = '0;
        i_write_data       = '0;
        i_rom_write_enable = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_RAM_SIZE_CODE;
        i_cfg_data         = '0;
        ram_code_q         = RST_RAM_CODE;
        rom_last_q         = RST_ROM_LAST;
        protect_q          = RST_PROTECT;
        latch_q            = RST_BOOT_LATCH;
        error_count        = 0;
        accesses_sent      = 0;
        burst_left         = 0;
        hold_request       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_decode_basics();
        test_write_protect();
        test_config_sweep();
        test_receiver_holdoff();

        drain_block();
        repeat (16) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
